>>> rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg: shared types for the counting semaphore
// Command and status codes, request and result beats, waiter queue control.
// ----------------------------------------------------------------------------
package csem_pkg;

    // fixed field widths
    localparam int C_CMD_W    = 2;
    localparam int C_THREAD_W = 8;
    localparam int C_PRIO_W   = 8;
    localparam int C_STATUS_W = 3;
    localparam int C_CFG_W    = 16;
    localparam int C_CNT_OUT_W = 16;
    localparam int C_CNT_WIDE_W = 32;

    // operation codes
    typedef enum logic [C_CMD_W-1:0] {
        CMD_WAIT   = 2'd0,
        CMD_TRY    = 2'd1,
        CMD_SIGNAL = 2'd2,
        CMD_DRAIN  = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [C_STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_TRY_FAIL  = 3'd2,
        ST_WOKE      = 3'd3,
        ST_RAISED    = 3'd4,
        ST_FULL      = 3'd5,
        ST_SATURATED = 3'd6
    } t_status;

    // one request beat
    typedef struct packed {
        t_cmd                  cmd;
        logic [C_THREAD_W-1:0] thread;
        logic [C_PRIO_W-1:0]   prio;
        logic                  present;
    } t_req;

    // one result beat
    typedef struct packed {
        t_status                status;
        logic                   woken_valid;
        logic [C_THREAD_W-1:0]  woken_thread;
        logic                   reschedule;
        logic [C_CNT_OUT_W-1:0] count_after;
    } t_rsp;

    // one queued waiter
    typedef struct packed {
        logic [C_THREAD_W-1:0] id;
        logic [C_PRIO_W-1:0]   prio;
    } t_waiter;

    // queue control from the semaphore logic
    typedef struct packed {
        logic push;
        logic pop;
    } t_wq_ctrl;

    // queue status back to the semaphore logic
    typedef struct packed {
        logic empty;
        logic full;
    } t_wq_stat;

endpackage

>>> rtl/csem_req_if.sv
// ----------------------------------------------------------------------------
// csem_req_if: request channel
// Valid/ready channel carrying one semaphore operation per beat.
// ----------------------------------------------------------------------------
interface csem_req_if;
    logic                            valid;
    logic                            ready;
    logic [csem_pkg::C_CMD_W-1:0]    command;
    logic [csem_pkg::C_THREAD_W-1:0] caller_thread;
    logic [csem_pkg::C_PRIO_W-1:0]   caller_priority;
    logic                            caller_present;

    modport source (
        output valid, command, caller_thread, caller_priority, caller_present,
        input  ready
    );

    modport sink (
        input  valid, command, caller_thread, caller_priority, caller_present,
        output ready
    );
endinterface

>>> rtl/csem_rsp_if.sv
// ----------------------------------------------------------------------------
// csem_rsp_if: result channel
// Valid/ready channel carrying one semaphore result per beat.
// ----------------------------------------------------------------------------
interface csem_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [csem_pkg::C_STATUS_W-1:0]  status;
    logic                             woken_valid;
    logic [csem_pkg::C_THREAD_W-1:0]  woken_thread;
    logic                             reschedule;
    logic [csem_pkg::C_CNT_OUT_W-1:0] count_after;

    modport source (
        output valid, status, woken_valid, woken_thread, reschedule, count_after,
        input  ready
    );

    modport sink (
        input  valid, status, woken_valid, woken_thread, reschedule, count_after,
        output ready
    );
endinterface

>>> rtl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters: counting semaphore with FIFO wait queue
// Keeps a unit count and a ring of waiting threads, one operation per beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per beat (wait, try-wait, signal, wait and
//   drain) with the caller's thread id, priority and presence flag.
//   o_rsp returns exactly one result beat per request, in order: status,
//   the woken waiter on signal, a reschedule hint and the count afterwards.
//   i_cfg_we / i_cfg_wdata load the live count while no waiter is queued;
//   with waiters queued the write has no effect. Write only when idle.
// Timing:
//   a request beat lands in an input register and is resolved from there
//   against the count and the head waiter; its result then goes to the
//   output register, once that register is free or o_rsp is taking it.
//   Throughput is one beat per cycle while o_rsp does not stall, set by the
//   update of the count and the queue head/tail with a registered head read.
// Reset and stall:
//   reset clears the count and empties the queue; no memory sweep is needed.
//   When o_rsp stalls, the output register holds its beat and the input
//   register still takes one more; i_req.ready drops only when both are full.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
    parameter int WAITER_DEPTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [csem_pkg::C_CFG_W-1:0]   i_cfg_wdata,
    csem_req_if.sink                       i_req,
    csem_rsp_if.source                     o_rsp
);

    logic                    r_a_valid;
    csem_pkg::t_req          r_a;
    logic                    r_o_valid;
    csem_pkg::t_rsp          r_o;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [COUNT_WIDTH-1:0]  n_count;
    logic [csem_pkg::C_CNT_WIDE_W-1:0] count_wide;
    logic                    a_fire;
    logic                    in_fire;
    logic                    count_nz;
    logic                    count_max;
    csem_pkg::t_rsp          rsp;
    csem_pkg::t_wq_ctrl      wq_ctrl;
    csem_pkg::t_wq_ctrl      op_ctrl;
    csem_pkg::t_wq_stat      wq_stat;
    csem_pkg::t_waiter       head_entry;
    csem_pkg::t_waiter       push_entry;

    // handshake between the two register stages
    assign a_fire      = r_a_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || a_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a.cmd     <= csem_pkg::t_cmd'(i_req.command);
            r_a.thread  <= i_req.caller_thread;
            r_a.prio    <= i_req.caller_priority;
            r_a.present <= i_req.caller_present;
        end
    end

    assign count_nz  = (r_count != '0);
    assign count_max = (r_count == '1);

    assign push_entry.id   = r_a.thread;
    assign push_entry.prio = r_a.prio;

    // resolve one operation against the count and the head waiter
    always_comb begin
        n_count          = r_count;
        op_ctrl          = '0;
        rsp.status       = csem_pkg::ST_GRANTED;
        rsp.woken_valid  = 1'b0;
        rsp.woken_thread = '0;
        rsp.reschedule   = 1'b0;
        unique case (r_a.cmd)
            csem_pkg::CMD_SIGNAL: begin
                if (!wq_stat.empty) begin
                    op_ctrl.pop      = 1'b1;
                    rsp.status       = csem_pkg::ST_WOKE;
                    rsp.woken_valid  = 1'b1;
                    rsp.woken_thread = head_entry.id;
                    rsp.reschedule   = r_a.present && (head_entry.prio < r_a.prio);
                end else if (count_max) begin
                    rsp.status = csem_pkg::ST_SATURATED;
                end else begin
                    n_count    = r_count + 1'b1;
                    rsp.status = csem_pkg::ST_RAISED;
                end
            end
            csem_pkg::CMD_TRY: begin
                if (count_nz) begin
                    n_count    = r_count - 1'b1;
                    rsp.status = csem_pkg::ST_GRANTED;
                end else begin
                    rsp.status = csem_pkg::ST_TRY_FAIL;
                end
            end
            csem_pkg::CMD_WAIT, csem_pkg::CMD_DRAIN: begin
                if (count_nz) begin
                    n_count    = (r_a.cmd == csem_pkg::CMD_DRAIN) ? '0 : (r_count - 1'b1);
                    rsp.status = csem_pkg::ST_GRANTED;
                end else if (!wq_stat.full) begin
                    op_ctrl.push = 1'b1;
                    rsp.status   = csem_pkg::ST_QUEUED;
                end else begin
                    rsp.status = csem_pkg::ST_FULL;
                end
            end
        endcase
        count_wide      = csem_pkg::C_CNT_WIDE_W'(n_count);
        rsp.count_after = count_wide[csem_pkg::C_CNT_OUT_W-1:0];
    end

    // queue moves only when the operation retires
    assign wq_ctrl.push = a_fire && op_ctrl.push;
    assign wq_ctrl.pop  = a_fire && op_ctrl.pop;

    // count register, loaded by a write only while no one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            priority if (a_fire) begin
                r_count <= n_count;
            end else if (i_cfg_we && wq_stat.empty) begin
                r_count <= COUNT_WIDTH'(i_cfg_wdata);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_o <= rsp;
        end
    end

    csem_wait_queue #(
        .WAITER_DEPTH (WAITER_DEPTH)
    ) u_wait_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (wq_ctrl),
        .i_push_entry (push_entry),
        .o_head_entry (head_entry),
        .o_stat       (wq_stat)
    );

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o.status;
    assign o_rsp.woken_valid  = r_o.woken_valid;
    assign o_rsp.woken_thread = r_o.woken_thread;
    assign o_rsp.reschedule   = r_o.reschedule;
    assign o_rsp.count_after  = r_o.count_after;

`ifndef SYNTH
    a_woken_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.woken_valid) |-> (o_rsp.status == csem_pkg::ST_WOKE))
        else $error("woken waiter without woke status");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_a_valid && r_o_valid && !o_rsp.ready))
        else $error("request stalled with room in the pipeline");

    a_try_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && (r_a.cmd == csem_pkg::CMD_TRY) && count_nz)
        |=> (r_count == ($past(r_count) - COUNT_WIDTH'(1))))
        else $error("granted try-wait did not take a unit");
`endif

endmodule

>>> rtl/csem_wait_queue.sv
// ----------------------------------------------------------------------------
// csem_wait_queue: ring of waiting threads
// Ring memory with head pointer and fill count; the head entry is kept in a
// read register that always matches the current head slot.
// ----------------------------------------------------------------------------
module csem_wait_queue #(
    parameter int WAITER_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csem_pkg::t_wq_ctrl i_ctrl,
    input  csem_pkg::t_waiter  i_push_entry,
    output csem_pkg::t_waiter  o_head_entry,
    output csem_pkg::t_wq_stat o_stat
);

    localparam int IDX_W  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int FILL_W = $clog2(WAITER_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    csem_pkg::t_waiter r_mem [WAITER_DEPTH];
    csem_pkg::t_waiter r_rd;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  tail_wrap;
    logic [IDX_W-1:0]  tail;
    logic              empty;
    logic              full;

    assign empty = (r_fill == '0);
    assign full  = (r_fill == FILL_W'(WAITER_DEPTH));

    // tail slot, head plus fill folded into the ring
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_fill);
    assign tail_wrap = (tail_sum >= SUM_W'(WAITER_DEPTH)) ?
                       (tail_sum - SUM_W'(WAITER_DEPTH)) : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];

    // head advance on pop
    always_comb begin
        n_head = r_head;
        if (i_ctrl.pop) begin
            n_head = (r_head == IDX_W'(WAITER_DEPTH - 1)) ? '0 : (r_head + 1'b1);
        end
    end

    // fill count update
    always_comb begin
        n_fill = r_fill;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // ring write and head read, with bypass when the new head is being written
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[tail] <= i_push_entry;
        end
        if (i_ctrl.push && (tail == n_head)) begin
            r_rd <= i_push_entry;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    assign o_head_entry = r_rd;
    assign o_stat.empty = empty;
    assign o_stat.full  = full;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WAITER_DEPTH))
        else $error("waiter fill count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> !full)
        else $error("push into full waiter queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> !empty)
        else $error("pop from empty waiter queue");

    a_head_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.push && empty) |=> (o_head_entry == $past(i_push_entry)))
        else $error("head entry missed push into empty queue");
`endif

endmodule

>>> dv/counting_semaphore_fifo_waiters_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_tb: self-checking bench for the semaphore
// Drives wait, try-wait, signal and drain beats through the request channel
// under random sender bursts and receiver stalls. Every result beat is checked
// against an in-bench model of the count and the waiter ring. The run moves
// through several initial-count settings, including zero and the maximum.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_tb;

    localparam int WAITER_DEPTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam logic [csem_pkg::C_CNT_OUT_W-1:0] COUNT_MAX =
        csem_pkg::C_CNT_OUT_W'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam int OPS_PER_SETTING = 237;
    localparam int NUM_SETTINGS    = 8;

    // traffic shapes for the random part
    typedef enum int {
        MIX_FILL,
        MIX_RELEASE,
        MIX_EVEN
    } t_mix;

    // in-bench semaphore model and store of expected result beats
    class semaphore_tracker;
        logic [csem_pkg::C_CNT_OUT_W-1:0] units;
        logic [csem_pkg::C_CFG_W-1:0]     initial_value;
        csem_pkg::t_waiter                ring[WAITER_DEPTH];
        int                               ring_head;
        int                               ring_fill;
        csem_pkg::t_rsp                   pending_results[$];
        int                               errors;
        int                               ops_seen;
        int                               results_seen;
        int                               fill_peak;
        int                               resched_seen;
        int                               status_seen[7];

        // reset state
        function void clear();
            units         = '0;
            initial_value = '0;
            ring_head     = 0;
            ring_fill     = 0;
        endfunction

        // register write: the live count follows only while no one waits
        function void load_initial(logic [csem_pkg::C_CFG_W-1:0] v);
            initial_value = v;
            if (ring_fill == 0)
                units = v & COUNT_MAX;
        endfunction

        // resolve one accepted operation and queue the result it must give
        function void accept_op(csem_pkg::t_req r);
            csem_pkg::t_rsp    e;
            csem_pkg::t_waiter w;
            e = '0;
            e.status = csem_pkg::ST_GRANTED;
            case (r.cmd)
                csem_pkg::CMD_SIGNAL: begin
                    if (ring_fill > 0) begin
                        w              = ring[ring_head];
                        e.woken_valid  = 1'b1;
                        e.woken_thread = w.id;
                        e.reschedule   = r.present && (w.prio < r.prio);
                        e.status       = csem_pkg::ST_WOKE;
                        ring_head      = (ring_head + 1) % WAITER_DEPTH;
                        ring_fill--;
                    end else if (units == COUNT_MAX) begin
                        e.status = csem_pkg::ST_SATURATED;
                    end else begin
                        units++;
                        e.status = csem_pkg::ST_RAISED;
                    end
                end
                csem_pkg::CMD_TRY: begin
                    if (units != 0) begin
                        units--;
                        e.status = csem_pkg::ST_GRANTED;
                    end else begin
                        e.status = csem_pkg::ST_TRY_FAIL;
                    end
                end
                default: begin
                    // wait and drain share the grant/queue path
                    if (units != 0) begin
                        units--;
                        if (r.cmd == csem_pkg::CMD_DRAIN)
                            units = '0;
                        e.status = csem_pkg::ST_GRANTED;
                    end else if (ring_fill < WAITER_DEPTH) begin
                        ring[(ring_head + ring_fill) % WAITER_DEPTH] = '{r.thread, r.prio};
                        ring_fill++;
                        e.status = csem_pkg::ST_QUEUED;
                    end else begin
                        e.status = csem_pkg::ST_FULL;
                    end
                end
            endcase
            e.count_after = units;
            if (ring_fill > fill_peak)
                fill_peak = ring_fill;
            if (e.reschedule)
                resched_seen++;
            status_seen[e.status]++;
            ops_seen++;
            pending_results.push_back(e);
        endfunction

        // compare one result beat with the oldest expectation
        function void compare_result(csem_pkg::t_rsp got);
            csem_pkg::t_rsp exp_rsp;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d count %0d",
                       got.status, got.count_after);
                errors++;
                return;
            end
            exp_rsp = pending_results.pop_front();
            results_seen++;
            if (got.status !== exp_rsp.status) begin
                $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
                errors++;
            end
            if (got.woken_valid !== exp_rsp.woken_valid) begin
                $error("woken_valid: expected %0d, actual %0d",
                       exp_rsp.woken_valid, got.woken_valid);
                errors++;
            end
            if (got.woken_thread !== exp_rsp.woken_thread) begin
                $error("woken_thread: expected %0d, actual %0d",
                       exp_rsp.woken_thread, got.woken_thread);
                errors++;
            end
            if (got.reschedule !== exp_rsp.reschedule) begin
                $error("reschedule: expected %0d, actual %0d",
                       exp_rsp.reschedule, got.reschedule);
                errors++;
            end
            if (got.count_after !== exp_rsp.count_after) begin
                $error("count_after: expected %0d, actual %0d",
                       exp_rsp.count_after, got.count_after);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [csem_pkg::C_CFG_W-1:0]  i_cfg_wdata;

    csem_req_if req_ch ();
    csem_rsp_if rsp_ch ();

    semaphore_tracker tracker;
    int               rx_hold_req;
    int               rx_holds_done;
    int               settings_done;

    counting_semaphore_fifo_waiters #(
        .WAITER_DEPTH (WAITER_DEPTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // beat monitor on both channels
    always @(posedge i_clk) begin
        csem_pkg::t_req op;
        csem_pkg::t_rsp got;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                op.cmd     = csem_pkg::t_cmd'(req_ch.command);
                op.thread  = req_ch.caller_thread;
                op.prio    = req_ch.caller_priority;
                op.present = req_ch.caller_present;
                tracker.accept_op(op);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status       = csem_pkg::t_status'(rsp_ch.status);
                got.woken_valid  = rsp_ch.woken_valid;
                got.woken_thread = rsp_ch.woken_thread;
                got.reschedule   = rsp_ch.reschedule;
                got.count_after  = rsp_ch.count_after;
                tracker.compare_result(got);
            end
        end
    end

    // receiver: full-speed stretches, random stall patterns, requested long holds
    initial begin
        logic [15:0] pattern;
        int          seg_len;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req > 0) begin
                seg_len     = rx_hold_req;
                rx_hold_req = 0;
                pattern     = '0;
                rx_holds_done++;
            end else if ($urandom_range(0, 3) == 0) begin
                seg_len = $urandom_range(5, 40);
                pattern = '1;
            end else begin
                seg_len = $urandom_range(8, 64);
                pattern = 16'($urandom);
                if (pattern == '0)
                    pattern[0] = 1'b1;
            end
            for (int c = 0; c < seg_len; c++) begin
                @(negedge i_clk);
                rsp_ch.ready <= pattern[c % 16];
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic csem_pkg::t_req make_op(csem_pkg::t_cmd cmd, logic [7:0] thread,
                                               logic [7:0] prio, logic present);
        csem_pkg::t_req r;
        r.cmd     = cmd;
        r.thread  = thread;
        r.prio    = prio;
        r.present = present;
        return r;
    endfunction

    // random operation, command weights follow the traffic shape
    function automatic csem_pkg::t_req random_op(t_mix mix);
        int             roll;
        csem_pkg::t_cmd cmd;
        csem_pkg::t_req r;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                cmd = (roll < 45) ? csem_pkg::CMD_WAIT :
                      (roll < 60) ? csem_pkg::CMD_DRAIN :
                      (roll < 75) ? csem_pkg::CMD_TRY : csem_pkg::CMD_SIGNAL;
            MIX_RELEASE:
                cmd = (roll < 60) ? csem_pkg::CMD_SIGNAL :
                      (roll < 80) ? csem_pkg::CMD_WAIT :
                      (roll < 90) ? csem_pkg::CMD_TRY : csem_pkg::CMD_DRAIN;
            default:
                cmd = csem_pkg::t_cmd'(2'(roll % 4));
        endcase
        r.cmd    = cmd;
        r.thread = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       r.prio = 8'h00;
            1:       r.prio = 8'hff;
            default: r.prio = 8'($urandom);
        endcase
        r.present = ($urandom_range(0, 3) != 0);
        return r;
    endfunction

    // offer one beat from the next falling edge until it is taken
    task automatic send_op(input csem_pkg::t_req r);
        @(negedge i_clk);
        req_ch.valid           <= 1'b1;
        req_ch.command         <= r.cmd;
        req_ch.caller_thread   <= r.thread;
        req_ch.caller_priority <= r.prio;
        req_ch.caller_present  <= r.present;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic tx_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle_tx();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_initial(input logic [csem_pkg::C_CFG_W-1:0] v);
        settle_tx();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.load_initial(v);
        settings_done++;
    endtask

    // main sequence
    initial begin
        logic [csem_pkg::C_CFG_W-1:0] setting_values[NUM_SETTINGS];
        t_mix                         mix;
        int                           mix_left;
        int                           sent;
        int                           blen;
        bit                           paused;
        bit                           held;

        tracker = new;
        tracker.clear();
        rx_hold_req   = 0;
        rx_holds_done = 0;
        settings_done = 0;
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_wdata            = '0;
        req_ch.valid           = 1'b0;
        req_ch.command         = csem_pkg::CMD_WAIT;
        req_ch.caller_thread   = '0;
        req_ch.caller_priority = '0;
        req_ch.caller_present  = 1'b0;
        rsp_ch.ready           = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation at the top, drain, then a full waiter ring
        write_initial(16'hffff);
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h01, 8'h80, 1'b1));
        send_op(make_op(csem_pkg::CMD_TRY,    8'h02, 8'h80, 1'b1));
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h03, 8'h80, 1'b0));
        send_op(make_op(csem_pkg::CMD_DRAIN,  8'h04, 8'h80, 1'b1));
        send_op(make_op(csem_pkg::CMD_TRY,    8'h05, 8'h80, 1'b1));
        for (int i = 0; i < WAITER_DEPTH; i++) begin
            if (i == 0)
                send_op(make_op(csem_pkg::CMD_WAIT, 8'h00, 8'h00, 1'b0));
            else if (i == WAITER_DEPTH - 1)
                send_op(make_op(csem_pkg::CMD_WAIT, 8'hff, 8'hff, 1'b1));
            else
                send_op(make_op(csem_pkg::CMD_WAIT, 8'($urandom_range(1, 254)),
                                8'(i * 16), 1'b1));
        end
        send_op(make_op(csem_pkg::CMD_WAIT,   8'h10, 8'h10, 1'b1));
        send_op(make_op(csem_pkg::CMD_DRAIN,  8'h11, 8'h10, 1'b1));
        // woken waiter outranks caller, then no caller, then caller ahead, then a tie
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h20, 8'hff, 1'b1));
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h21, 8'hff, 1'b0));
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h22, 8'h00, 1'b1));
        send_op(make_op(csem_pkg::CMD_SIGNAL, 8'h23, 8'h30, 1'b1));
        // waiters still queued: the live count does not move
        write_initial(16'h0005);

        // random part over several count settings
        setting_values = '{16'h0000, 16'hffff, 16'h0001, 16'h0002,
                           16'($urandom), 16'hfffe, 16'h0003, 16'($urandom)};
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_initial(setting_values[p]);
            sent     = 0;
            mix_left = 0;
            mix      = MIX_EVEN;
            paused   = 1'b0;
            held     = 1'b0;
            while (sent < OPS_PER_SETTING) begin
                if (mix_left <= 0) begin
                    mix      = t_mix'($urandom_range(0, 2));
                    mix_left = $urandom_range(20, 60);
                end
                blen = $urandom_range(1, 24);
                for (int k = 0; k < blen; k++) begin
                    send_op(random_op(mix));
                    sent++;
                    mix_left--;
                end
                if (!held && (p % 3 == 1) && sent > OPS_PER_SETTING / 4) begin
                    // long receiver hold while the sender keeps pushing
                    rx_hold_req = 60;
                    held        = 1'b1;
                end else if ($urandom_range(0, 3) != 0) begin
                    tx_gap($urandom_range(1, 8));
                end
                if (!paused && sent > OPS_PER_SETTING / 2) begin
                    settle_tx();
                    paused = 1'b1;
                end
            end
        end

        // drain and let the pipe go quiet
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run: %0d operations, %0d results over %0d count settings",
                 tracker.ops_seen, tracker.results_seen, settings_done);
        $display("ring peak %0d, %0d long holds, grant %0d queue %0d tryfail %0d",
                 tracker.fill_peak, rx_holds_done, tracker.status_seen[0],
                 tracker.status_seen[1], tracker.status_seen[2]);
        $display("woke %0d raise %0d full %0d sat %0d resched %0d",
                 tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5],
                 tracker.status_seen[6], tracker.resched_seen);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/csem_pkg.sv
rtl/csem_req_if.sv
rtl/csem_rsp_if.sv
rtl/csem_wait_queue.sv
rtl/counting_semaphore_fifo_waiters.sv
dv/counting_semaphore_fifo_waiters_tb.sv
